/* design/urm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urm_pkg
// Types, operation codes, register indexes and status bit positions shared by
// the UART register model modules.
// ----------------------------------------------------------------------------
package urm_pkg;

   // Operation codes of an input item.
   localparam logic [2:0] OP_READ   = 3'd0;
   localparam logic [2:0] OP_WRITE  = 3'd1;
   localparam logic [2:0] OP_TICK   = 3'd2;
   localparam logic [2:0] OP_INJECT = 3'd3;
   localparam logic [2:0] OP_ACK    = 3'd4;

   // Register indexes.
   localparam logic [2:0] REG_DATA   = 3'd0;
   localparam logic [2:0] REG_STATUS = 3'd1;
   localparam logic [2:0] REG_CTRL_B = 3'd2;
   localparam logic [2:0] REG_CTRL_C = 3'd3;
   localparam logic [2:0] REG_BAUD_L = 3'd4;
   localparam logic [2:0] REG_BAUD_H = 3'd5;

   // Interrupt causes.
   localparam logic [1:0] CAUSE_RXC  = 2'd0;
   localparam logic [1:0] CAUSE_UDRE = 2'd1;
   localparam logic [1:0] CAUSE_TXC  = 2'd2;

   // Status register bits.
   localparam int ST_RXC  = 7;
   localparam int ST_TXC  = 6;
   localparam int ST_UDRE = 5;
   localparam int ST_U2X  = 1;

   // Control B enable bits.
   localparam int CB_RXCIE = 7;
   localparam int CB_TXCIE = 6;
   localparam int CB_UDRIE = 5;

   // Reset values and limits.
   localparam logic [7:0]  STATUS_RESET = 8'h20;
   localparam logic [7:0]  CTRL_C_RESET = 8'h06;
   localparam logic [3:0]  BAUD_H_MASK  = 4'hF;
   localparam logic [19:0] TX_LEN_RESET = 20'd160;
   localparam logic [19:0] TX_CNT_MAX   = 20'hFFFFF;

   typedef struct packed {
      logic [2:0]  operation;
      logic [2:0]  reg_index;
      logic [7:0]  write_data;
      logic [15:0] elapsed;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_pending;
      logic [1:0] irq_cause;
      logic       tx_valid;
      logic [7:0] tx_data;
   } rsp_type;

endpackage

/* design/uart_register_model.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_register_model
// Register-level UART model with bus access, time ticks, receive injection
// and interrupt acknowledge.
// ----------------------------------------------------------------------------
// Each request item is applied to the register state in the cycle it is
// accepted, and its single result item appears on the response channel on
// the following cycle. One item is taken per clock cycle for as long as the
// response side keeps up; the only thing that holds requests back is a full
// result register whose item is being stalled by the consumer. The limit on
// throughput is the one-deep result register, which frees itself in the same
// cycle as its item is taken.
// A data write starts a transmit of length (8 with double speed, else 16) times
// (divisor + 1) times 10; tick items add their elapsed count to a
// saturating 20-bit counter, setting data-empty on the first non-zero count
// and transmit-complete when the length is reached. Interrupts are prioritised
// receive, data empty, transmit complete, each gated by its control B enable.
// ----------------------------------------------------------------------------
module uart_register_model
   import urm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   logic    accept;
   logic    can_load;
   rsp_type result;

   // A request is taken whenever the result register can accept its result.
   assign req_stall = !can_load;
   assign accept    = req_valid && can_load;

   // State update and result formation in one short combinational pass.
   urm_core u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (req_item),
      .result (result)
   );

   // One-item result register between the state and the consumer.
   urm_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .result    (result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .can_load  (can_load)
   );

endmodule

/* design/urm_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urm_core
// Register file and next-state logic: applies one item per accepted cycle and
// forms its result.
// ----------------------------------------------------------------------------
module urm_core
   import urm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type item,
   output rsp_type result
);

   logic [7:0]  rx_byte_ff, rx_byte_in;
   logic [7:0]  tx_byte_ff, tx_byte_in;
   logic [7:0]  status_ff, status_in;
   logic [7:0]  ctrl_b_ff, ctrl_b_in;
   logic [7:0]  ctrl_c_ff, ctrl_c_in;
   logic [7:0]  baud_l_ff, baud_l_in;
   logic [3:0]  baud_h_ff, baud_h_in;
   logic        tx_busy_ff, tx_busy_in;
   logic [19:0] tx_count_ff, tx_count_in;
   logic [19:0] tx_length_ff, tx_length_in;

   logic [12:0] baud_p1;
   logic [16:0] times10;
   logic [19:0] len_calc;
   logic [20:0] count_sum;
   logic [19:0] count_sat;
   logic [7:0]  rd;
   logic [7:0]  status_mid;
   logic        pend;
   logic [1:0]  cause;

   // Frame length: (8 or 16) * (divisor + 1) * 10, the times ten as two shifts.
   assign baud_p1   = {1'b0, baud_h_ff, baud_l_ff} + 13'd1;
   assign times10   = {1'b0, baud_p1, 3'b000} + {3'b000, baud_p1, 1'b0};
   assign len_calc  = status_ff[ST_U2X] ? {times10, 3'b000} : {times10[15:0], 4'b0000};
   assign count_sum = {1'b0, tx_count_ff} + {5'd0, item.elapsed};
   assign count_sat = count_sum[20] ? TX_CNT_MAX : count_sum[19:0];

   always_comb begin
      rx_byte_in   = rx_byte_ff;
      tx_byte_in   = tx_byte_ff;
      status_mid   = status_ff;
      ctrl_b_in    = ctrl_b_ff;
      ctrl_c_in    = ctrl_c_ff;
      baud_l_in    = baud_l_ff;
      baud_h_in    = baud_h_ff;
      tx_busy_in   = tx_busy_ff;
      tx_count_in  = tx_count_ff;
      tx_length_in = tx_length_ff;
      rd           = 8'd0;
      case (item.operation)
         OP_READ: begin
            case (item.reg_index)
               REG_DATA: begin
                  rd = rx_byte_ff;
                  status_mid[ST_RXC] = 1'b0;
               end
               REG_STATUS: rd = status_ff;
               REG_CTRL_B: rd = ctrl_b_ff;
               REG_CTRL_C: rd = ctrl_c_ff;
               REG_BAUD_L: rd = baud_l_ff;
               REG_BAUD_H: rd = {4'd0, baud_h_ff};
               default:    rd = 8'd0;
            endcase
         end
         OP_WRITE: begin
            case (item.reg_index)
               REG_DATA: begin
                  tx_byte_in          = item.write_data;
                  status_mid[ST_UDRE] = 1'b0;
                  status_mid[ST_TXC]  = 1'b0;
                  tx_busy_in          = 1'b1;
                  tx_count_in         = 20'd0;
                  tx_length_in        = len_calc;
               end
               REG_STATUS: begin
                  status_mid[ST_U2X] = item.write_data[ST_U2X];
                  if (item.write_data[ST_TXC]) begin
                     status_mid[ST_TXC] = 1'b0;
                  end
               end
               REG_CTRL_B: ctrl_b_in = item.write_data;
               REG_CTRL_C: ctrl_c_in = item.write_data;
               REG_BAUD_L: baud_l_in = item.write_data;
               REG_BAUD_H: baud_h_in = item.write_data[3:0] & BAUD_H_MASK;
               default:    ;
            endcase
         end
         OP_TICK: begin
            if (tx_busy_ff) begin
               tx_count_in = count_sat;
               if (count_sat != 20'd0) begin
                  status_mid[ST_UDRE] = 1'b1;
               end
               if (count_sat >= tx_length_ff) begin
                  tx_busy_in         = 1'b0;
                  status_mid[ST_TXC] = 1'b1;
               end
            end
         end
         OP_INJECT: begin
            rx_byte_in         = item.write_data;
            status_mid[ST_RXC] = 1'b1;
         end
         default: ;
      endcase

      // Fixed priority: receive, data empty, transmit complete.
      pend  = 1'b1;
      cause = CAUSE_RXC;
      if (status_mid[ST_RXC] && ctrl_b_in[CB_RXCIE]) begin
         cause = CAUSE_RXC;
      end else if (status_mid[ST_UDRE] && ctrl_b_in[CB_UDRIE]) begin
         cause = CAUSE_UDRE;
      end else if (status_mid[ST_TXC] && ctrl_b_in[CB_TXCIE]) begin
         cause = CAUSE_TXC;
      end else begin
         pend = 1'b0;
      end

      status_in = status_mid;
      if (item.operation == OP_ACK && pend) begin
         case (cause)
            CAUSE_RXC:  status_in[ST_RXC]  = 1'b0;
            CAUSE_UDRE: status_in[ST_UDRE] = 1'b0;
            default:    status_in[ST_TXC]  = 1'b0;
         endcase
      end

      result.read_data   = rd;
      result.irq_pending = pend;
      result.irq_cause   = pend ? cause : CAUSE_RXC;
      result.tx_valid    = status_in[ST_TXC];
      result.tx_data     = tx_byte_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_byte_ff   <= 8'd0;
         tx_byte_ff   <= 8'd0;
         status_ff    <= STATUS_RESET;
         ctrl_b_ff    <= 8'd0;
         ctrl_c_ff    <= CTRL_C_RESET;
         baud_l_ff    <= 8'd0;
         baud_h_ff    <= 4'd0;
         tx_busy_ff   <= 1'b0;
         tx_count_ff  <= 20'd0;
         tx_length_ff <= TX_LEN_RESET;
      end else if (accept) begin
         rx_byte_ff   <= rx_byte_in;
         tx_byte_ff   <= tx_byte_in;
         status_ff    <= status_in;
         ctrl_b_ff    <= ctrl_b_in;
         ctrl_c_ff    <= ctrl_c_in;
         baud_l_ff    <= baud_l_in;
         baud_h_ff    <= baud_h_in;
         tx_busy_ff   <= tx_busy_in;
         tx_count_ff  <= tx_count_in;
         tx_length_ff <= tx_length_in;
      end
   end

`ifndef SYNTHESIS
   // A data write always leaves a transmit in progress.
   a_write_starts_tx: assert property (@(posedge clock) disable iff (reset)
      accept && item.operation == OP_WRITE && item.reg_index == REG_DATA |=> tx_busy_ff)
      else $error("data write did not start a transmit");

   // Ticks while idle leave the transmit counter alone.
   a_idle_tick_holds: assert property (@(posedge clock) disable iff (reset)
      accept && item.operation == OP_TICK && !tx_busy_ff |=> $stable(tx_count_ff))
      else $error("idle tick changed the transmit count");

   // Only the defined status bits can ever be set.
   a_status_unused_zero: assert property (@(posedge clock) disable iff (reset)
      status_ff[4:2] == 3'd0 && status_ff[0] == 1'b0)
      else $error("undefined status bit set");

   // A finished transmit always shows the transmit-complete flag.
   a_done_sets_txc: assert property (@(posedge clock) disable iff (reset)
      accept && item.operation == OP_TICK && tx_busy_ff && !tx_busy_in
      |=> status_ff[ST_TXC])
      else $error("transmit ended without transmit-complete");
`endif

endmodule

/* design/urm_out.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urm_out
// Result register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module urm_out
   import urm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type result,
   input  logic    rsp_stall,
   output logic    rsp_valid,
   output rsp_type rsp_item,
   output logic    can_load
);

   logic    valid_ff, valid_in;
   rsp_type item_ff;

   // The slot can take a new item when empty or when its item leaves now.
   assign can_load = !valid_ff || !rsp_stall;
   assign valid_in = load ? 1'b1 : (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

/* tb/sv/uart_register_model_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_register_model_checker
// Watches both channels of the UART register model, predicts the reply to
// each accepted request item and compares every reply as it is taken.
// ----------------------------------------------------------------------------
module uart_register_model_checker
   import urm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_item,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_item,
   output int      replies_owed,
   output int      failures
);

   // Shadow copy of the register file and the transmit timer.
   logic [7:0]  rx_hold;
   logic [7:0]  tx_hold;
   logic [7:0]  status_bits;
   logic [7:0]  ctrl_b;
   logic [7:0]  ctrl_c;
   logic [7:0]  divisor_low;
   logic [3:0]  divisor_high;
   logic        sending;
   logic [19:0] sent_cycles;
   logic [19:0] frame_cycles;

   rsp_type expected_replies[$];
   int      mismatch_count = 0;
   int      reply_number = 0;

   // Applies one request item to the shadow state and returns its reply.
   function automatic rsp_type apply_uart_request(input req_type item);
      rsp_type     reply;
      logic [20:0] total;
      int          frame;
      logic        pending;
      logic [1:0]  cause;
      reply = '0;
      pending = 1'b0;
      cause = CAUSE_RXC;
      case (item.operation)
         OP_READ: begin
            case (item.reg_index)
               REG_DATA: begin
                  reply.read_data = rx_hold;
                  status_bits[ST_RXC] = 1'b0;
               end
               REG_STATUS: reply.read_data = status_bits;
               REG_CTRL_B: reply.read_data = ctrl_b;
               REG_CTRL_C: reply.read_data = ctrl_c;
               REG_BAUD_L: reply.read_data = divisor_low;
               REG_BAUD_H: reply.read_data = {4'h0, divisor_high};
               default: reply.read_data = 8'h00;
            endcase
         end
         OP_WRITE: begin
            case (item.reg_index)
               REG_DATA: begin
                  tx_hold = item.write_data;
                  status_bits[ST_UDRE] = 1'b0;
                  status_bits[ST_TXC] = 1'b0;
                  sending = 1'b1;
                  sent_cycles = '0;
                  frame = (status_bits[ST_U2X] ? 8 : 16)
                          * (int'({divisor_high, divisor_low}) + 1) * 10;
                  frame_cycles = frame[19:0];
               end
               REG_STATUS: begin
                  status_bits[ST_U2X] = item.write_data[ST_U2X];
                  if (item.write_data[ST_TXC]) begin
                     status_bits[ST_TXC] = 1'b0;
                  end
               end
               REG_CTRL_B: ctrl_b = item.write_data;
               REG_CTRL_C: ctrl_c = item.write_data;
               REG_BAUD_L: divisor_low = item.write_data;
               REG_BAUD_H: divisor_high = item.write_data[3:0] & BAUD_H_MASK;
               default: ;
            endcase
         end
         OP_TICK: begin
            if (sending) begin
               total = {1'b0, sent_cycles} + {5'd0, item.elapsed};
               sent_cycles = (total > {1'b0, TX_CNT_MAX}) ? TX_CNT_MAX : total[19:0];
               if (sent_cycles != '0) begin
                  status_bits[ST_UDRE] = 1'b1;
               end
               if (sent_cycles >= frame_cycles) begin
                  sending = 1'b0;
                  status_bits[ST_TXC] = 1'b1;
               end
            end
         end
         OP_INJECT: begin
            rx_hold = item.write_data;
            status_bits[ST_RXC] = 1'b1;
         end
         default: ;
      endcase

      if (status_bits[ST_RXC] && ctrl_b[CB_RXCIE]) begin
         pending = 1'b1;
         cause = CAUSE_RXC;
      end else if (status_bits[ST_UDRE] && ctrl_b[CB_UDRIE]) begin
         pending = 1'b1;
         cause = CAUSE_UDRE;
      end else if (status_bits[ST_TXC] && ctrl_b[CB_TXCIE]) begin
         pending = 1'b1;
         cause = CAUSE_TXC;
      end

      if (item.operation == OP_ACK && pending) begin
         case (cause)
            CAUSE_RXC:  status_bits[ST_RXC] = 1'b0;
            CAUSE_UDRE: status_bits[ST_UDRE] = 1'b0;
            default:    status_bits[ST_TXC] = 1'b0;
         endcase
      end

      reply.irq_pending = pending;
      reply.irq_cause = pending ? cause : CAUSE_RXC;
      reply.tx_valid = status_bits[ST_TXC];
      reply.tx_data = tx_hold;
      return reply;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      logic    wrong;
      if (reset) begin
         rx_hold = '0;
         tx_hold = '0;
         status_bits = STATUS_RESET;
         ctrl_b = '0;
         ctrl_c = CTRL_C_RESET;
         divisor_low = '0;
         divisor_high = '0;
         sending = 1'b0;
         sent_cycles = '0;
         frame_cycles = TX_LEN_RESET;
         expected_replies.delete();
      end else begin
         // Replies are retired before new requests are predicted, so a reply
         // that arrives with nothing owed is never matched against this
         // edge's request.
         if (rsp_valid && !rsp_stall) begin
            reply_number++;
            if (expected_replies.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: reply %0d arrived with nothing owed", $realtime,
                           reply_number);
               end
            end else begin
               want = expected_replies.pop_front();
               wrong = (rsp_item.read_data !== want.read_data)
                       || (rsp_item.irq_pending !== want.irq_pending)
                       || (rsp_item.irq_cause !== want.irq_cause)
                       || (rsp_item.tx_valid !== want.tx_valid)
                       || (rsp_item.tx_data !== want.tx_data);
               if (wrong) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: reply %0d expected rd=%h irq=%b cause=%0d txv=%b txd=%h",
                              $realtime, reply_number, want.read_data, want.irq_pending,
                              want.irq_cause, want.tx_valid, want.tx_data);
                     $display("%0t: reply %0d actual   rd=%h irq=%b cause=%0d txv=%b txd=%h",
                              $realtime, reply_number, rsp_item.read_data,
                              rsp_item.irq_pending, rsp_item.irq_cause,
                              rsp_item.tx_valid, rsp_item.tx_data);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_replies.push_back(apply_uart_request(req_item));
         end
      end
      replies_owed <= expected_replies.size();
      failures <= mismatch_count;
   end

endmodule

/* tb/sv/uart_register_model_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_register_model_tb
// Drives request items into the UART register model and gives the verdict.
// A short directed sequence walks through the register map, the transmit
// timer and the interrupt priority; a long random sequence follows, with
// random idling on both channels and one long hold-off of the reply side.
// ----------------------------------------------------------------------------
module uart_register_model_tb;
   import urm_pkg::*;

   // Operation codes and register indexes that the block does not decode.
   localparam logic [2:0] OP_SPARE_LO  = 3'd5;
   localparam logic [2:0] OP_SPARE_HI  = 3'd7;
   localparam logic [2:0] REG_SPARE_LO = 3'd6;
   localparam logic [2:0] REG_SPARE_HI = 3'd7;

   localparam int RANDOM_ITEMS = 1150;
   localparam int CALM_FROM    = 950;
   localparam int HOLD_AFTER   = 400;
   localparam int HOLD_CYCLES  = 80;
   localparam int CYCLE_LIMIT  = 200000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;

   int replies_owed;
   int failures;

   // idle_rate and items_sent are shared between the two driving processes. idle_rate is the chance,
   // one in idle_rate, that a burst of idling starts; zero means none.
   int idle_rate = 0;
   int items_sent = 0;
   int cycle_count;

   uart_register_model DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   uart_register_model_checker checker_inst (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_item     (req_item),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_item     (rsp_item),
      .replies_owed (replies_owed),
      .failures     (failures)
   );

   initial begin
      forever begin
         #10 clock = ~clock;
      end
   end

   function automatic req_type make_item(input logic [2:0] operation,
                                         input logic [2:0] reg_index,
                                         input logic [7:0] write_data,
                                         input logic [15:0] elapsed);
      req_type item;
      item.operation = operation;
      item.reg_index = reg_index;
      item.write_data = write_data;
      item.elapsed = elapsed;
      return item;
   endfunction

   // Builds one random request. Writes lean towards the data register so
   // that transmits start often, and ticks come in a mix of
   // short and long steps so that both flags of a transmit get set apart as
   // well as together. Fields that an operation ignores are random too.
   function automatic req_type pick_random_item();
      req_type item;
      int      roll;
      item.operation = OP_READ;
      item.reg_index = 3'($urandom_range(0, 7));
      item.write_data = 8'($urandom_range(0, 255));
      item.elapsed = 16'($urandom_range(0, 65535));
      roll = $urandom_range(0, 99);
      if (roll < 22) begin
         item.operation = OP_READ;
         if ($urandom_range(0, 9) != 0) begin
            item.reg_index = 3'($urandom_range(REG_DATA, REG_BAUD_H));
         end
      end else if (roll < 52) begin
         item.operation = OP_WRITE;
         if ($urandom_range(0, 2) == 0) begin
            item.reg_index = REG_DATA;
         end
         // Keep the divisor mostly short so that transmits finish in a few
         // ticks; now and then a large one is left in place.
         if (item.reg_index == REG_BAUD_H && $urandom_range(0, 3) != 0) begin
            item.write_data[3:0] = 4'h0;
         end
      end else if (roll < 75) begin
         item.operation = OP_TICK;
         case ($urandom_range(0, 2))
            0: item.elapsed = 16'($urandom_range(0, 200));
            1: item.elapsed = 16'($urandom_range(0, 4000));
            default: ;
         endcase
      end else if (roll < 85) begin
         item.operation = OP_INJECT;
      end else if (roll < 97) begin
         item.operation = OP_ACK;
      end else begin
         item.operation = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      end
      return item;
   endfunction

   // Offers one item, starting and returning at a falling edge, and keeps it
   // steady until the block accepts it. A burst of idling may go first.
   task automatic offer_item(input req_type item);
      int gap;
      if (idle_rate != 0 && $urandom_range(1, idle_rate) == 1) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 11);
         repeat (gap) @(negedge clock);
      end
      req_item <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      items_sent++;
      @(negedge clock);
   endtask

   // Request side: reset, directed items, random items, then the verdict.
   initial begin : stimulus
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset values, an unmapped read and an ignored unmapped write.
      offer_item(make_item(OP_READ, REG_STATUS, 8'h00, 16'h0000));
      offer_item(make_item(OP_READ, REG_CTRL_C, 8'hFF, 16'hFFFF));
      offer_item(make_item(OP_READ, REG_SPARE_HI, 8'h00, 16'h0000));
      offer_item(make_item(OP_WRITE, REG_SPARE_LO, 8'hFF, 16'h0000));
      // All enables on: data empty is pending from reset. The first
      // acknowledge takes it, the second finds nothing left.
      offer_item(make_item(OP_WRITE, REG_CTRL_B, 8'hE0, 16'h0000));
      offer_item(make_item(OP_ACK, REG_DATA, 8'h00, 16'h0000));
      offer_item(make_item(OP_ACK, REG_DATA, 8'h00, 16'h0000));
      // A received byte raises receive complete; reading data clears it.
      offer_item(make_item(OP_INJECT, REG_DATA, 8'hFF, 16'h0000));
      offer_item(make_item(OP_READ, REG_DATA, 8'h00, 16'h0000));
      // Only the low nibble of the divisor high byte is kept.
      offer_item(make_item(OP_WRITE, REG_BAUD_H, 8'hFF, 16'h0000));
      offer_item(make_item(OP_READ, REG_BAUD_H, 8'h00, 16'h0000));
      offer_item(make_item(OP_WRITE, REG_BAUD_H, 8'h00, 16'h0000));
      offer_item(make_item(OP_WRITE, REG_BAUD_L, 8'h00, 16'h0000));
      // A status write takes only double speed and the TXC clear bit.
      offer_item(make_item(OP_WRITE, REG_STATUS, 8'hFF, 16'h0000));
      offer_item(make_item(OP_READ, REG_STATUS, 8'h00, 16'h0000));
      // A tick with no transmit running changes nothing.
      offer_item(make_item(OP_TICK, REG_DATA, 8'h00, 16'hFFFF));
      // Transmit at double speed: a zero tick, then a tick of elapsed one sets data
      // empty, a second write restarts it and a long tick completes it.
      offer_item(make_item(OP_WRITE, REG_DATA, 8'hA5, 16'h0000));
      offer_item(make_item(OP_TICK, REG_DATA, 8'h00, 16'h0000));
      offer_item(make_item(OP_TICK, REG_DATA, 8'h00, 16'h0001));
      offer_item(make_item(OP_WRITE, REG_DATA, 8'h5A, 16'h0000));
      offer_item(make_item(OP_TICK, REG_DATA, 8'h00, 16'hFFFF));
      // Only the transmit complete interrupt enabled, then taken.
      offer_item(make_item(OP_WRITE, REG_CTRL_B, 8'h40, 16'h0000));
      offer_item(make_item(OP_ACK, REG_DATA, 8'h00, 16'h0000));
      offer_item(make_item(OP_WRITE, REG_CTRL_C, 8'hFF, 16'h0000));
      offer_item(make_item(OP_WRITE, REG_STATUS, 8'h00, 16'h0000));
      offer_item(make_item(OP_SPARE_HI, REG_SPARE_HI, 8'hFF, 16'hFFFF));

      // Random part. The idling rate changes every hundred items, including
      // stretches with none, and the last part runs without any idling.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 100 == 0) begin
            if (i >= CALM_FROM) begin
               idle_rate = 0;
            end else begin
               case ($urandom_range(0, 3))
                  0: idle_rate = 0;
                  1: idle_rate = 2;
                  2: idle_rate = 4;
                  default: idle_rate = 8;
               endcase
            end
         end
         offer_item(pick_random_item());
      end
      req_valid <= 1'b0;

      // The run waits until the checker owes no reply before it gives the
      // verdict.
      while (replies_owed != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
      if (failures == 0) begin
         $display("uart_register_model: match");
      end else begin
         $display("uart_register_model: mismatch");
      end
      $finish;
   end

   // Reply side. Once enough items have gone through, the reply channel is
   // held off for a long stretch while requests keep coming, so the one-deep
   // result register fills and the block has to stall its input. Otherwise
   // idling comes in short random bursts at the shared rate.
   initial begin : reply_side
      int  held;
      logic long_hold_done;
      long_hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (!long_hold_done && items_sent >= HOLD_AFTER) begin
            rsp_stall <= 1'b1;
            for (held = 0; held < HOLD_CYCLES; held++) begin
               @(negedge clock);
            end
            rsp_stall <= 1'b0;
            long_hold_done = 1'b1;
         end else if (idle_rate != 0 && $urandom_range(1, idle_rate) == 1) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // A run that hangs ends here as a failure.
   initial begin : watchdog
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) begin
         @(posedge clock);
      end
      $display("uart_register_model: mismatch");
      $finish;
   end

endmodule

/* files.f */
design/urm_pkg.sv
design/urm_core.sv
design/urm_out.sv
design/uart_register_model.sv
tb/sv/uart_register_model_checker.sv
tb/sv/uart_register_model_tb.sv
